@@ sv/csb_pkg.sv @@
// Shared types, constants and helper functions for the centred sprite scaler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package csb_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_TEX_SIDE_DEF = 128;
  localparam int SCREEN_W_DEF     = 1280;
  localparam int SCREEN_H_DEF     = 720;

  // Fixed field widths.
  localparam int COORD_W    = 10;
  localparam int SCREEN_C_W = 11;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int TEX_REG_W  = 8;
  localparam int SCALE_W    = 4;

  // Texel index carried through the queue; wide enough for the largest side.
  localparam int TEX_IDX_W = 9;

  // Signed width of a centred screen coordinate before clipping.
  localparam int SX_W = 14;

  // Reciprocal multiply used to divide a box coordinate by the scale.
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = COORD_W + RECIP_W;

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  localparam logic [COLOR_W-1:0] COLOR_KEY = 32'hFF00_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH  = 2'd0,
    CFG_TEX_HEIGHT = 2'd1,
    CFG_SCALE      = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_code_t;

  // What the back end does with one queued transaction.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_SAMPLE
  } op_kind_t;

  typedef struct packed {
    logic                 command;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [COLOR_W-1:0]   texel_value;
  } cmd_t;

  typedef struct packed {
    logic                  write_enable;
    logic [SCREEN_C_W-1:0] screen_x;
    logic [SCREEN_C_W-1:0] screen_y;
    logic [COLOR_W-1:0]    pixel_color;
  } pix_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [TEX_IDX_W-1:0]  tx;
    logic [TEX_IDX_W-1:0]  ty;
    logic [SCREEN_C_W-1:0] sx;
    logic [SCREEN_C_W-1:0] sy;
    logic [COLOR_W-1:0]    data;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // ceil(2^16 / s): (n * recip(s)) >> 16 equals n / s exactly for n below 1024.
  function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    case (s)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      4'd12:   r = 17'd5462;
      4'd13:   r = 17'd5042;
      4'd14:   r = 17'd4682;
      4'd15:   r = 17'd4370;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/csb_front.sv @@
// Front end: accepts command transactions, checks range, box and screen clipping,
// and forms texel indices by reciprocal multiply. Uses csb_pkg.
`default_nettype none

module csb_front #(
  parameter int MAX_TEX_SIDE = csb_pkg::MAX_TEX_SIDE_DEF,
  parameter int SCREEN_W     = csb_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H     = csb_pkg::SCREEN_H_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_stall,
  input  wire csb_pkg::cmd_t                     cmd,
  input  wire logic [csb_pkg::TEX_REG_W-1:0]     tex_width,
  input  wire logic [csb_pkg::TEX_REG_W-1:0]     tex_height,
  input  wire logic [csb_pkg::SCALE_W-1:0]       scale,
  input  wire logic                              q_full,
  output csb_pkg::q_push_t                       q_push
);

  localparam int TW_W = $clog2(MAX_TEX_SIDE + 1);
  localparam int BW_W = TW_W + csb_pkg::SCALE_W;
  localparam int CW   = (BW_W > csb_pkg::COORD_W) ? BW_W : csb_pkg::COORD_W;
  localparam int SX_W = csb_pkg::SX_W;

  logic [TW_W-1:0]                  tw;
  logic [TW_W-1:0]                  th;
  logic [BW_W-1:0]                  bw;
  logic [BW_W-1:0]                  bh;
  logic [csb_pkg::RECIP_W-1:0]      rcp;
  logic [SX_W-1:0]                  sxw;
  logic [SX_W-1:0]                  syw;
  logic                             in_box;
  logic                             on_screen;
  logic                             load_ok;
  csb_pkg::op_kind_t                kind_in;
  logic                             accept;
  logic                             push;

  // Stage register behind the multipliers.
  logic                             f1_valid;
  csb_pkg::op_kind_t                f1_kind;
  logic [csb_pkg::TEX_IDX_W-1:0]    f1_cx;
  logic [csb_pkg::TEX_IDX_W-1:0]    f1_cy;
  logic [csb_pkg::PROD_W-1:0]       f1_prod_x;
  logic [csb_pkg::PROD_W-1:0]       f1_prod_y;
  logic [csb_pkg::SCREEN_C_W-1:0]   f1_sx;
  logic [csb_pkg::SCREEN_C_W-1:0]   f1_sy;
  logic [csb_pkg::COLOR_W-1:0]      f1_data;

  always_comb begin
    tw = ({2'b00, tex_width} > 10'(MAX_TEX_SIDE)) ? TW_W'(MAX_TEX_SIDE) : TW_W'(tex_width);
    th = ({2'b00, tex_height} > 10'(MAX_TEX_SIDE)) ? TW_W'(MAX_TEX_SIDE) : TW_W'(tex_height);
    bw = BW_W'(tw) * BW_W'(scale);
    bh = BW_W'(th) * BW_W'(scale);
    rcp = csb_pkg::recip(scale);

    // An empty box also fails these compares.
    in_box = (CW'(cmd.coord_x) < CW'(bw)) && (CW'(cmd.coord_y) < CW'(bh));

    sxw = SX_W'(cmd.coord_x) + SX_W'(SCREEN_W / 2) - SX_W'(bw >> 1);
    syw = SX_W'(cmd.coord_y) + SX_W'(SCREEN_H / 2) - SX_W'(bh >> 1);
    on_screen = !sxw[SX_W-1] && (sxw < SX_W'(SCREEN_W)) &&
                !syw[SX_W-1] && (syw < SX_W'(SCREEN_H));

    load_ok = ({1'b0, cmd.coord_x} < 11'(MAX_TEX_SIDE)) &&
              ({1'b0, cmd.coord_y} < 11'(MAX_TEX_SIDE));

    if (cmd.command == csb_pkg::CMD_LOAD) begin
      kind_in = load_ok ? csb_pkg::OP_LOAD : csb_pkg::OP_NONE;
    end else begin
      kind_in = (in_box && on_screen) ? csb_pkg::OP_SAMPLE : csb_pkg::OP_NONE;
    end
  end

  assign push      = f1_valid && !q_full;
  assign cmd_stall = f1_valid && q_full;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (push) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_kind   <= kind_in;
      f1_cx     <= csb_pkg::TEX_IDX_W'(cmd.coord_x);
      f1_cy     <= csb_pkg::TEX_IDX_W'(cmd.coord_y);
      f1_prod_x <= csb_pkg::PROD_W'(cmd.coord_x) * csb_pkg::PROD_W'(rcp);
      f1_prod_y <= csb_pkg::PROD_W'(cmd.coord_y) * csb_pkg::PROD_W'(rcp);
      f1_sx     <= sxw[csb_pkg::SCREEN_C_W-1:0];
      f1_sy     <= syw[csb_pkg::SCREEN_C_W-1:0];
      f1_data   <= cmd.texel_value;
    end
  end

  always_comb begin
    q_push.push       = push;
    q_push.entry.kind = f1_kind;
    q_push.entry.sx   = f1_sx;
    q_push.entry.sy   = f1_sy;
    q_push.entry.data = f1_data;
    if (f1_kind == csb_pkg::OP_LOAD) begin
      q_push.entry.tx = f1_cx;
      q_push.entry.ty = f1_cy;
    end else begin
      q_push.entry.tx = f1_prod_x[csb_pkg::RECIP_SHIFT +: csb_pkg::TEX_IDX_W];
      q_push.entry.ty = f1_prod_y[csb_pkg::RECIP_SHIFT +: csb_pkg::TEX_IDX_W];
    end
  end

  // The input is held off only while a finished transaction waits on the queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (f1_valid && q_full))
    else $error("front stalled without a waiting transaction");

  // A held transaction keeps its classification until it is pushed.
  a_hold_kind: assert property (@(posedge clk) disable iff (rst)
    (f1_valid && q_full) |=> (f1_valid && f1_kind == $past(f1_kind)))
    else $error("front transaction changed while blocked");

endmodule

`default_nettype wire

@@ sv/csb_fifo.sv @@
// Short queue that decouples the front end from the texture back end.
// Holds csb_pkg::q_entry_t transactions; uses csb_pkg.
`default_nettype none

module csb_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire csb_pkg::q_push_t  q_push,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output csb_pkg::q_entry_t      head
);

  localparam int PTR_W = $clog2(csb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(csb_pkg::QUEUE_DEPTH + 1);

  csb_pkg::q_entry_t  slots [csb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(csb_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = q_push.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_push.entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_push.push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

@@ sv/csb_back.sv @@
// Back end: texture store, registered texel read, color-key test and output register.
// Takes transactions from csb_fifo; uses csb_pkg.
`default_nettype none

module csb_back #(
  parameter int MAX_TEX_SIDE = csb_pkg::MAX_TEX_SIDE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  wire csb_pkg::q_entry_t  q_head,
  output logic                    pix_valid,
  input  wire logic               pix_stall,
  output csb_pkg::pix_t           pix
);

  localparam int SIDE_W = $clog2(MAX_TEX_SIDE);
  localparam int ADDR_W = 2 * SIDE_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [csb_pkg::COLOR_W-1:0]     store [DEPTH];
  logic [ADDR_W-1:0]               addr;

  logic                            b1_valid;
  csb_pkg::op_kind_t               b1_kind;
  logic [csb_pkg::SCREEN_C_W-1:0]  b1_sx;
  logic [csb_pkg::SCREEN_C_W-1:0]  b1_sy;
  logic [csb_pkg::COLOR_W-1:0]     rd_data;
  logic                            b1_adv;
  csb_pkg::pix_t                   pix_next;

  assign addr   = {q_head.ty[SIDE_W-1:0], q_head.tx[SIDE_W-1:0]};
  assign b1_adv = b1_valid && (!pix_valid || !pix_stall);
  assign q_pop  = !q_empty && (!b1_valid || b1_adv);

  // Single-port store: loads write, samples read; one per cycle unless stalled.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_head.kind == csb_pkg::OP_LOAD) begin
        store[addr] <= q_head.data;
      end
      if (q_head.kind == csb_pkg::OP_SAMPLE) begin
        rd_data <= store[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (q_pop) begin
      b1_valid <= 1'b1;
    end else if (b1_adv) begin
      b1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_kind <= q_head.kind;
      b1_sx   <= q_head.sx;
      b1_sy   <= q_head.sy;
    end
  end

  always_comb begin
    pix_next = '0;
    if (b1_kind == csb_pkg::OP_SAMPLE && rd_data != csb_pkg::COLOR_KEY) begin
      pix_next.write_enable = 1'b1;
      pix_next.screen_x     = b1_sx;
      pix_next.screen_y     = b1_sy;
      pix_next.pixel_color  = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (b1_adv) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_adv) begin
      pix <= pix_next;
    end
  end

  a_key_never_drawn: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix.write_enable) |-> (pix.pixel_color != csb_pkg::COLOR_KEY))
    else $error("color key written to screen");

  a_quiet_when_off: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix.write_enable) |->
      (pix.screen_x == '0 && pix.screen_y == '0 && pix.pixel_color == '0))
    else $error("nonzero fields on a result without write");

endmodule

`default_nettype wire

@@ sv/centred_sprite_scale_blit.sv @@
// Top level of the centred nearest-neighbor sprite scaler with color key.
// Instantiates csb_front, csb_fifo and csb_back; uses csb_pkg.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall / cmd): a load transaction writes one
//   32-bit texel at (coord_x, coord_y) of the texture store; a sample transaction
//   names a position inside the scaled sprite box. Every command transaction gives
//   exactly one result transaction on the pixel channel, in order.
//   Pixel channel (pix_valid / pix_stall / pix): write_enable is set when the
//   sampled texel lands on the screen and is not the key 0xFF000000; otherwise
//   every field of the result is zero. A load also returns such an empty result.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes
//   texture width, texture height and scale. cfg_ready is always high; write only
//   while no command is in flight.
// Timing: the front end registers the reciprocal multiply that turns a box
//   coordinate into a texel index, a four-entry queue follows, then the back end
//   does one store access per cycle when unstalled and registers the result. An accepted command
//   passes the front stage register, the queue, the store read register and the
//   output register to reach pix; unstalled, it takes one command per cycle, set by the single store port.
// Reset: synchronous and active high; it empties the pipeline and the queue and
//   sets width, height and scale to 1. The texture store is not cleared.
// Stall: while pix_stall is high the result holds; the back end and queue fill up,
//   and cmd_stall rises once the queue is full and the front stage is occupied.
`default_nettype none

module centred_sprite_scale_blit #(
  parameter int MAX_TEX_SIDE = csb_pkg::MAX_TEX_SIDE_DEF,
  parameter int SCREEN_W     = csb_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H     = csb_pkg::SCREEN_H_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_stall,
  input  wire csb_pkg::cmd_t                   cmd,
  output logic                                 pix_valid,
  input  wire logic                            pix_stall,
  output csb_pkg::pix_t                        pix,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [csb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [csb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [csb_pkg::TEX_REG_W-1:0]  tex_width;
  logic [csb_pkg::TEX_REG_W-1:0]  tex_height;
  logic [csb_pkg::SCALE_W-1:0]    scale;

  // Queue between the front and back ends.
  csb_pkg::q_push_t               q_push;
  csb_pkg::q_entry_t              q_head;
  logic                           q_full;
  logic                           q_empty;
  logic                           q_pop;

  // Configuration never waits; writes must only be issued while the block is idle, which the block does not check.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= csb_pkg::TEX_REG_W'(1);
      tex_height <= csb_pkg::TEX_REG_W'(1);
      scale      <= csb_pkg::SCALE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (csb_pkg::cfg_idx_t'(cfg_index))
        csb_pkg::CFG_TEX_WIDTH:  tex_width  <= cfg_data;
        csb_pkg::CFG_TEX_HEIGHT: tex_height <= cfg_data;
        csb_pkg::CFG_SCALE:      scale      <= cfg_data[csb_pkg::SCALE_W-1:0];
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

  csb_front #(
    .MAX_TEX_SIDE (MAX_TEX_SIDE),
    .SCREEN_W     (SCREEN_W),
    .SCREEN_H     (SCREEN_H)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .tex_width  (tex_width),
    .tex_height (tex_height),
    .scale      (scale),
    .q_full     (q_full),
    .q_push     (q_push)
  );

  csb_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .full   (q_full),
    .empty  (q_empty),
    .pop    (q_pop),
    .head   (q_head)
  );

  csb_back #(
    .MAX_TEX_SIDE (MAX_TEX_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

  // A held result must not change until the receiver takes it.
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_stall) |=> (pix_valid && $stable(pix)))
    else $error("stalled result changed");

  // The command side stalls only when the queue is full.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> q_full)
    else $error("command stalled with room in the queue");

endmodule

`default_nettype wire

@@ tb/tb_centred_sprite_scale_blit.sv @@
// Self-checking testbench for centred_sprite_scale_blit: loads texels, samples the
// scaled sprite box under random stalls and compares every pixel transaction.
// Depends on csb_pkg and the centred_sprite_scale_blit RTL only.
`default_nettype none

module tb_centred_sprite_scale_blit;

  localparam int TEX_SIDE   = csb_pkg::MAX_TEX_SIDE_DEF;
  localparam int STORE_SIZE = TEX_SIDE * TEX_SIDE;
  localparam int HALF_W     = csb_pkg::SCREEN_W_DEF / 2;
  localparam int HALF_H     = csb_pkg::SCREEN_H_DEF / 2;
  // Cycles with no handshake on any channel before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Cycles allowed after the last expected pixel for the pipeline to settle.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES = 12;
  // Commands per phase, counting the loads that samples bring in.
  localparam int ITEMS_PER_PHASE = 153;

  // Tracks the texture store and the configuration, predicts the pixel for each
  // accepted command and checks the pixel channel against those predictions.
  class sprite_blit_checker;
    logic [csb_pkg::COLOR_W-1:0]   texels [STORE_SIZE];
    bit                            loaded [STORE_SIZE];
    logic [csb_pkg::TEX_REG_W-1:0] tex_w = 8'd1;
    logic [csb_pkg::TEX_REG_W-1:0] tex_h = 8'd1;
    logic [csb_pkg::SCALE_W-1:0]   scale = 4'd1;
    csb_pkg::pix_t                 expected_pixels [$];
    int                            faults = 0;

    function int clamp_side(input int side);
      return (side > TEX_SIDE) ? TEX_SIDE : side;
    endfunction

    function int box_w();
      return clamp_side(int'(tex_w)) * int'(scale);
    endfunction

    function int box_h();
      return clamp_side(int'(tex_h)) * int'(scale);
    endfunction

    function void set_register(input csb_pkg::cfg_idx_t idx,
                               input logic [csb_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        csb_pkg::CFG_TEX_WIDTH:  tex_w = value;
        csb_pkg::CFG_TEX_HEIGHT: tex_h = value;
        csb_pkg::CFG_SCALE:      scale = value[csb_pkg::SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // Returns 1 when (x, y) lies inside a non-empty box, with the store address
    // of the nearest texel in idx.
    function bit texel_index(input int x, input int y, output int idx);
      int bw;
      int bh;
      int tx;
      int ty;
      bw = box_w();
      bh = box_h();
      idx = 0;
      if (bw == 0 || bh == 0 || x >= bw || y >= bh) return 1'b0;
      tx = (x * clamp_side(int'(tex_w))) / bw;
      ty = (y * clamp_side(int'(tex_h))) / bh;
      idx = (ty * TEX_SIDE + tx) % STORE_SIZE;
      return 1'b1;
    endfunction

    // Applies one command to the tracked store and returns the pixel it yields.
    function csb_pkg::pix_t blit_pixel(input csb_pkg::cmd_t c);
      csb_pkg::pix_t p;
      int   x;
      int   y;
      int   idx;
      int   sx;
      int   sy;
      p = '0;
      x = int'(c.coord_x);
      y = int'(c.coord_y);
      if (c.command == csb_pkg::CMD_LOAD) begin
        if (x < TEX_SIDE && y < TEX_SIDE) begin
          texels[y * TEX_SIDE + x] = c.texel_value;
          loaded[y * TEX_SIDE + x] = 1'b1;
        end
        return p;
      end
      if (!texel_index(x, y, idx)) return p;
      sx = x + HALF_W - box_w() / 2;
      sy = y + HALF_H - box_h() / 2;
      if (sx < 0 || sx >= csb_pkg::SCREEN_W_DEF || sy < 0 || sy >= csb_pkg::SCREEN_H_DEF)
        return p;
      if (texels[idx] == csb_pkg::COLOR_KEY) return p;
      p.write_enable = 1'b1;
      p.screen_x     = sx[csb_pkg::SCREEN_C_W-1:0];
      p.screen_y     = sy[csb_pkg::SCREEN_C_W-1:0];
      p.pixel_color  = texels[idx];
      return p;
    endfunction

    function void note_command(input csb_pkg::cmd_t c);
      expected_pixels.push_back(blit_pixel(c));
    endfunction

    function void check_pixel(input csb_pkg::pix_t got);
      csb_pkg::pix_t want;
      if (expected_pixels.size() == 0) begin
        $error("pixel transaction with no command outstanding: %h", got);
        faults++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.write_enable !== want.write_enable) begin
        $error("write_enable: expected %0d, got %0d", want.write_enable, got.write_enable);
        faults++;
      end
      if (got.screen_x !== want.screen_x) begin
        $error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
        faults++;
      end
      if (got.screen_y !== want.screen_y) begin
        $error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
        faults++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
        faults++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cmd_valid = 1'b0;
  logic                           cmd_stall;
  csb_pkg::cmd_t                  cmd = '0;
  logic                           pix_valid;
  logic                           pix_stall = 1'b0;
  csb_pkg::pix_t                  pix;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [csb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [csb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Percent of cycles in which each side holds off; changed between phases.
  int sender_idle   = 29;
  int receiver_idle = 84;
  int quiet_cycles  = 0;
  // Command transactions accepted so far, and bookkeeping for one phase.
  int items_sent    = 0;
  int phase_start   = 0;
  bit mid_done      = 1'b0;

  sprite_blit_checker sb = new();

  centred_sprite_scale_blit uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random; with receiver_idle at zero it never stalls.
  always @(posedge clk) begin
    if (rst) begin
      pix_stall <= 1'b0;
    end else begin
      pix_stall <= ($urandom_range(99) < receiver_idle);
    end
  end

  // Every pixel transaction is checked at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) begin
      sb.check_pixel(pix);
    end
  end

  // Watchdog: a long stretch without any accepted transaction means a hang.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (pix_valid && !pix_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("centred_sprite_scale_blit test failed");
        $finish;
      end
    end
  end

  // Presents one command and holds it until accepted. The prediction is made
  // here, in the driving process, so the stimulus can rely on the tracked store
  // as soon as this task returns. Valid stays high afterwards, so back-to-back
  // commands never lower and raise it within one time step.
  task automatic send_command(input csb_pkg::cmd_t c);
    while ($urandom_range(99) < sender_idle) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    sb.note_command(c);
    items_sent++;
  endtask

  task automatic load_texel(input int x, input int y,
                            input logic [csb_pkg::COLOR_W-1:0] value);
    csb_pkg::cmd_t c;
    c.command     = csb_pkg::CMD_LOAD;
    c.coord_x     = x[csb_pkg::COORD_W-1:0];
    c.coord_y     = y[csb_pkg::COORD_W-1:0];
    c.texel_value = value;
    send_command(c);
  endtask

  // Mostly random colors, with the key now and then so that transparent texels
  // show up inside real sprites.
  function automatic logic [csb_pkg::COLOR_W-1:0] pick_color();
    return ($urandom_range(9) == 0) ? csb_pkg::COLOR_KEY : $urandom();
  endfunction

  // Samples one box position. A texel that was never loaded must not be read,
  // so if the position maps to such a texel it is loaded first.
  task automatic sample_at(input int x, input int y);
    csb_pkg::cmd_t c;
    int   idx;
    x = x & 1023;
    y = y & 1023;
    if (sb.texel_index(x, y, idx) && !sb.loaded[idx]) begin
      load_texel(idx % TEX_SIDE, idx / TEX_SIDE, pick_color());
    end
    c.command     = csb_pkg::CMD_SAMPLE;
    c.coord_x     = x[csb_pkg::COORD_W-1:0];
    c.coord_y     = y[csb_pkg::COORD_W-1:0];
    c.texel_value = $urandom();
    send_command(c);
  endtask

  // Stops sending and waits until every predicted pixel has come back, then
  // lets the pipeline settle. Registers are only written after this.
  task automatic drain_pixels();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input csb_pkg::cfg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[csb_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, value[csb_pkg::CFG_DATA_W-1:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random stimulus step. Well-formed samples inside the box dominate;
  // the rest are loads, box edges and positions anywhere in the range.
  task automatic random_item();
    int pick;
    int bw;
    int bh;
    int x;
    int y;
    pick = $urandom_range(99);
    bw   = sb.box_w();
    bh   = sb.box_h();
    if (pick < 55 && bw > 0 && bh > 0) begin
      sample_at($urandom_range(bw - 1), $urandom_range(bh - 1));
    end else if (pick < 70) begin
      load_texel($urandom_range(TEX_SIDE - 1), $urandom_range(TEX_SIDE - 1), pick_color());
    end else if (pick < 80) begin
      // Box borders: first and last position inside, first one outside, far end.
      case ($urandom_range(3))
        0:       x = 0;
        1:       x = bw - 1;
        2:       x = bw;
        default: x = 1023;
      endcase
      case ($urandom_range(3))
        0:       y = 0;
        1:       y = bh - 1;
        2:       y = bh;
        default: y = 1023;
      endcase
      sample_at(x, y);
    end else if (pick < 90) begin
      sample_at($urandom_range(1023), $urandom_range(1023));
    end else begin
      load_texel($urandom_range(1023), $urandom_range(1023), $urandom());
    end
  endtask

  // Phase settings: width, height, scale. They include the largest box, the
  // smallest one, oversize sides, an empty box, a box exactly as tall as the
  // screen and boxes taller than the screen so that rows fall off both edges.
  int phase_w [PHASES] = '{128,   1, 200,  37, 100, 128,   5, 255,  64,   0,   3,  90};
  int phase_h [PHASES] = '{128,   1, 255,  12, 100,  64,  90,   1, 128,  17, 128, 127};
  int phase_s [PHASES] = '{  8,   1,   8,   3,   8,   1,   8,   2,   5,   4,   7,   6};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first at the reset configuration: a one-texel box.
    load_texel(0, 0, 32'hFFFF_FFFF);
    sample_at(0, 0);
    load_texel(0, 0, csb_pkg::COLOR_KEY);     // transparent texel, no write
    sample_at(0, 0);
    load_texel(0, 0, 32'h0000_0000);          // black without alpha is not the key
    sample_at(0, 0);
    load_texel(TEX_SIDE, 0, 32'hDEAD_BEEF);   // loads outside the store are dropped
    load_texel(0, TEX_SIDE, 32'h5555_AAAA);
    load_texel(1023, 1023, 32'h1234_5678);
    sample_at(0, 0);
    sample_at(1, 0);                          // just outside the box
    sample_at(0, 1);
    sample_at(1023, 1023);
    drain_pixels();

    // A zero width leaves the box empty.
    write_cfg(csb_pkg::CFG_TEX_WIDTH, 0);
    sample_at(0, 0);
    drain_pixels();

    // Oversize sides clamp to the store side; at scale 8 the box is 1024 rows
    // tall, so its top and bottom rows fall off the screen.
    write_cfg(csb_pkg::CFG_TEX_WIDTH, 255);
    write_cfg(csb_pkg::CFG_TEX_HEIGHT, 200);
    write_cfg(csb_pkg::CFG_SCALE, 8);
    sample_at(1023, 152);                     // far right column, top screen row
    sample_at(0, 151);                        // one row above the screen
    sample_at(0, 871);                        // bottom screen row
    sample_at(0, 872);                        // one row below the screen
    sample_at(517, 600);
    drain_pixels();

    // Zero scale also empties the box.
    write_cfg(csb_pkg::CFG_SCALE, 0);
    sample_at(5, 5);
    drain_pixels();

    // Random part. The sender idles more than the receiver in the middle third
    // and neither idles in the last third. Halfway through each phase the sender
    // waits for every outstanding pixel before going on.
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        sender_idle   = 84;
        receiver_idle = 29;
      end else if (p == 2 * PHASES / 3) begin
        sender_idle   = 0;
        receiver_idle = 0;
      end
      drain_pixels();
      write_cfg(csb_pkg::CFG_TEX_WIDTH, phase_w[p]);
      write_cfg(csb_pkg::CFG_TEX_HEIGHT, phase_h[p]);
      write_cfg(csb_pkg::CFG_SCALE, phase_s[p]);
      phase_start = items_sent;
      mid_done    = 1'b0;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        if (!mid_done && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
          drain_pixels();
          mid_done = 1'b1;
        end
        random_item();
      end
    end
    drain_pixels();

    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("centred_sprite_scale_blit test passed");
    end else begin
      $display("centred_sprite_scale_blit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
